// ===== sv/sev_pkg.sv =====
// Shared types and constants for the Smagorinsky eddy viscosity pipeline.
// Holds field widths, stage counts, register indexes and reset values.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sev_pkg;

    // Field widths of the stream payload and the register port.
    localparam int GRAD_W    = 32;
    localparam int SIZE_W    = 32;
    localparam int CFG_W     = 32;
    localparam int OUT_W     = 32;
    localparam int IN_W      = 9 * GRAD_W + SIZE_W;
    localparam int CFG_IDX_W = 2;

    // Internal datapath widths.
    // ACC_W is the saturated width of the product chain.
    // RAD_W holds the squared strain norm, NORM_W its square root.
    localparam int ACC_W  = 64;
    localparam int RAD_W  = 2 * GRAD_W + 2;
    localparam int NORM_W = 34;

    // Pipeline timing.
    localparam int STRAIN_LAT = 4;
    localparam int MUL_LAT    = 2;
    localparam int H_DLY      = 2 * MUL_LAT;
    localparam int ACC_DLY    = STRAIN_LAT + NORM_W - 4 * MUL_LAT;
    localparam int PIPE_DEPTH = STRAIN_LAT + NORM_W + MUL_LAT + 1;

    // Saturation limit of the result.
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOL_VISC   = 2'd0,
        CFG_DENSITY    = 2'd1,
        CFG_SMAG_COEFF = 2'd2
    } t_cfg_idx;

    // Register values after reset.
    localparam logic [CFG_W-1:0] RST_MOL_VISC   = 32'd0;
    localparam logic [CFG_W-1:0] RST_DENSITY    = 32'd65536;
    localparam logic [CFG_W-1:0] RST_SMAG_COEFF = 32'd11141;

    // Input item; the last member sits in the lowest bits of tdata.
    typedef struct packed {
        logic        [SIZE_W-1:0] elem_size;
        logic signed [GRAD_W-1:0] dwz_dz;
        logic signed [GRAD_W-1:0] dwz_dy;
        logic signed [GRAD_W-1:0] dwz_dx;
        logic signed [GRAD_W-1:0] dvy_dz;
        logic signed [GRAD_W-1:0] dvy_dy;
        logic signed [GRAD_W-1:0] dvy_dx;
        logic signed [GRAD_W-1:0] dux_dz;
        logic signed [GRAD_W-1:0] dux_dy;
        logic signed [GRAD_W-1:0] dux_dx;
    } t_in_item;

endpackage

`default_nettype wire

// ===== sv/smagorinsky_eddy_viscosity.sv =====
// Smagorinsky eddy viscosity, one quadrature point per transaction. The block
// takes one point in every clock cycle while the result stream does not stall
// and returns its effective viscosity mol_viscosity + density * smag_coeff^2 *
// elem_size^2 * |S|, saturated at all ones: 4 stages form the squared strain
// norm, 34 stages take its square root one bit per stage, 2 stages make the last
// fixed-point product, 1 stage adds and saturates, and an output register with a
// skid entry holds the result. The coefficient and size products run in
// parallel with the square root. A stall on the result stream stops the whole
// pipeline once the skid entry fills, without losing data. The user must write
// registers only while no point is in flight; the block does not enforce this.
`default_nettype none

module smagorinsky_eddy_viscosity #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Point stream.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // Bits up from 0: dux_dx, dux_dy, dux_dz, dvy_dx, dvy_dy, dvy_dz,
    // dwz_dx, dwz_dy, dwz_dz, elem_size; 32 bits each.
    input  logic [sev_pkg::IN_W-1:0]        i_s_tdata,
    // Result stream.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // Bits up from 0: eff_viscosity.
    output logic [sev_pkg::OUT_W-1:0]       o_m_tdata,
    // Register write port.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sev_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sev_pkg::CFG_W-1:0]       i_cfg_data
);
    import sev_pkg::*;

    t_in_item          in_item;
    logic              en;

    logic [CFG_W-1:0]  r_mol_visc;
    logic [CFG_W-1:0]  r_density;
    logic [CFG_W-1:0]  r_smag_coeff;

    logic              r_vld [0:PIPE_DEPTH-1];
    logic [SIZE_W-1:0] r_h   [0:H_DLY-1];
    logic [ACC_W-1:0]  r_acc [0:ACC_DLY-1];

    logic [RAD_W-1:0]  rad;
    logic [NORM_W-1:0] norm;
    logic [ACC_W-1:0]  acc_cc;
    logic [ACC_W-1:0]  acc_h1;
    logic [ACC_W-1:0]  acc_h2;
    logic [ACC_W-1:0]  acc_rho;
    logic [ACC_W-1:0]  acc_all;
    logic [ACC_W:0]    total;
    logic [OUT_W-1:0]  r_res;

    assign in_item     = t_in_item'(i_s_tdata);
    assign o_s_tready  = en;
    assign o_cfg_ready = 1'b1;

    // Register writes; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mol_visc   <= RST_MOL_VISC;
            r_density    <= RST_DENSITY;
            r_smag_coeff <= RST_SMAG_COEFF;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MOL_VISC:   r_mol_visc   <= i_cfg_data;
                CFG_DENSITY:    r_density    <= i_cfg_data;
                CFG_SMAG_COEFF: r_smag_coeff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits move with the data whenever the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_s_tvalid;
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // Element size waits until each size product starts.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h[0] <= in_item.elem_size;
            for (int i = 1; i < H_DLY; i++) begin
                r_h[i] <= r_h[i-1];
            end
        end
    end

    // Strain norm path.
    sev_strain u_strain (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_item (in_item),
        .o_rad  (rad)
    );

    sev_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (rad),
        .o_root (norm)
    );

    // Product chain in the order coeff * coeff * size * size * density.
    sev_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_cc (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (ACC_W'(r_smag_coeff)),
        .i_b   (NORM_W'(r_smag_coeff)),
        .o_q   (acc_cc)
    );

    sev_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_h1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (acc_cc),
        .i_b   (NORM_W'(r_h[MUL_LAT-1])),
        .o_q   (acc_h1)
    );

    sev_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_h2 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (acc_h1),
        .i_b   (NORM_W'(r_h[H_DLY-1])),
        .o_q   (acc_h2)
    );

    sev_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_rho (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (acc_h2),
        .i_b   (NORM_W'(r_density)),
        .o_q   (acc_rho)
    );

    // Hold the coefficient product until the square root is done.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_acc[0] <= acc_rho;
            for (int i = 1; i < ACC_DLY; i++) begin
                r_acc[i] <= r_acc[i-1];
            end
        end
    end

    sev_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_norm (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_acc[ACC_DLY-1]),
        .i_b   (norm),
        .o_q   (acc_all)
    );

    // Add the molecular part and saturate.
    assign total = (ACC_W+1)'(acc_all) + (ACC_W+1)'(r_mol_visc);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= (total >= (ACC_W+1)'(OUT_MAX)) ? OUT_MAX : total[OUT_W-1:0];
        end
    end

    // Result stream; its free slot is the pipeline enable.
    sev_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[PIPE_DEPTH-1]),
        .o_ready (en),
        .i_data  (r_res),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata)
    );

endmodule

`default_nettype wire

// ===== sv/sev_strain.sv =====
// Squared strain-rate norm: cross sums, squares, and the halved total.
// Four register stages that advance together on the pipeline enable.
// Depends on sev_pkg.
`default_nettype none

module sev_strain (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  sev_pkg::t_in_item          i_item,
    output logic [sev_pkg::RAD_W-1:0]  o_rad
);
    import sev_pkg::*;

    logic signed [GRAD_W-1:0]   r_diag  [0:2];
    logic signed [GRAD_W:0]     r_cross [0:2];
    logic        [2*GRAD_W-1:0] r_dsq   [0:2];
    logic        [2*GRAD_W:0]   r_csq   [0:2];
    logic        [2*GRAD_W-1:0] r_dsum;
    logic        [RAD_W-1:0]    r_csum;
    logic        [RAD_W-1:0]    r_rad;

    logic signed [2*GRAD_W-1:0] dsq_full [0:2];
    logic signed [2*GRAD_W+1:0] csq_full [0:2];

    // Squares of the diagonal gradients and of the cross sums.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dsq_full[i] = (2*GRAD_W)'(r_diag[i]) * (2*GRAD_W)'(r_diag[i]);
            csq_full[i] = (2*GRAD_W+2)'(r_cross[i]) * (2*GRAD_W+2)'(r_cross[i]);
        end
    end

    // Stage 1 takes the diagonal terms and forms the exact cross sums.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diag[0]  <= i_item.dux_dx;
            r_diag[1]  <= i_item.dvy_dy;
            r_diag[2]  <= i_item.dwz_dz;
            r_cross[0] <= {i_item.dux_dy[GRAD_W-1], i_item.dux_dy}
                        + {i_item.dvy_dx[GRAD_W-1], i_item.dvy_dx};
            r_cross[1] <= {i_item.dux_dz[GRAD_W-1], i_item.dux_dz}
                        + {i_item.dwz_dx[GRAD_W-1], i_item.dwz_dx};
            r_cross[2] <= {i_item.dvy_dz[GRAD_W-1], i_item.dvy_dz}
                        + {i_item.dwz_dy[GRAD_W-1], i_item.dwz_dy};
        end
    end

    // Stage 2 registers the squares; both kinds are never negative.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_dsq[i] <= dsq_full[i];
                r_csq[i] <= csq_full[i][2*GRAD_W:0];
            end
        end
    end

    // Stage 3 sums each group; stage 4 forms floor of the full sum over two.
    // The doubled diagonal sum is even, so only the cross sum loses its low bit.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dsum <= r_dsq[0] + r_dsq[1] + r_dsq[2];
            r_csum <= RAD_W'(r_csq[0]) + RAD_W'(r_csq[1]) + RAD_W'(r_csq[2]);
            r_rad  <= RAD_W'(r_dsum) + RAD_W'(r_csum[RAD_W-1:1]);
        end
    end

    assign o_rad = r_rad;

endmodule

`default_nettype wire

// ===== sv/sev_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Each stage keeps the partial root and the remainder of the radicand.
// Depends on sev_pkg.
`default_nettype none

module sev_isqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [sev_pkg::RAD_W-1:0]   i_rad,
    output logic [sev_pkg::NORM_W-1:0]  o_root
);
    import sev_pkg::*;

    localparam int TRY_W = RAD_W + 2;

    logic [RAD_W-1:0]  r_rem  [0:NORM_W-2];
    logic [NORM_W-1:0] r_root [0:NORM_W-1];

    for (genvar k = 0; k < NORM_W; k++) begin : g_stage
        localparam int B = NORM_W - 1 - k;

        logic [RAD_W-1:0]  rem_in;
        logic [NORM_W-1:0] root_in;
        logic [TRY_W-1:0]  trial;
        logic [TRY_W-1:0]  diff;
        logic              take;

        if (k == 0) begin : g_first
            assign rem_in  = i_rad;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        // Setting bit B grows the square by 2*root*2^B + 2^(2B).
        assign trial = (TRY_W'(root_in) << (B + 1)) + (TRY_W'(1) << (2 * B));
        assign take  = TRY_W'(rem_in) >= trial;
        assign diff  = TRY_W'(rem_in) - trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= take ? (root_in | (NORM_W'(1) << B)) : root_in;
            end
        end

        // The last stage needs no remainder.
        if (k < NORM_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= take ? diff[RAD_W-1:0] : rem_in;
                end
            end
        end
    end

    assign o_root = r_root[NORM_W-1];

endmodule

`default_nettype wire

// ===== sv/sev_fxmul.sv =====
// Two-stage fixed-point multiplier: 64-bit operand times 34-bit operand,
// scaled down by the fraction width, truncated and saturated to 64 bits.
// Depends on sev_pkg.
`default_nettype none

module sev_fxmul #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [sev_pkg::ACC_W-1:0]   i_a,
    input  logic [sev_pkg::NORM_W-1:0]  i_b,
    output logic [sev_pkg::ACC_W-1:0]   o_q
);
    import sev_pkg::*;

    localparam int HALF_W = ACC_W / 2;
    localparam int PP_W   = HALF_W + NORM_W;
    localparam int FULL_W = ACC_W + NORM_W;

    logic [PP_W-1:0]   r_plo;
    logic [PP_W-1:0]   r_phi;
    logic [FULL_W-1:0] full;
    logic [ACC_W-1:0]  r_q;

    // Stage 1: two partial products, one for each half of the wide operand.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plo <= PP_W'(i_a[HALF_W-1:0]) * PP_W'(i_b);
            r_phi <= PP_W'(i_a[ACC_W-1:HALF_W]) * PP_W'(i_b);
        end
    end

    assign full = FULL_W'(r_plo) + (FULL_W'(r_phi) << HALF_W);

    // Stage 2: drop the fraction bits, clamp anything past 64 bits.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= (|full[FULL_W-1:ACC_W+FRAC_BITS]) ? '1
                                                     : full[ACC_W-1+FRAC_BITS:FRAC_BITS];
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ===== sv/sev_skid.sv =====
// Output register with one skid entry between the pipeline and the result stream.
// The upstream ready comes from a register, so the pipeline stall is not
// a combinational path from the downstream ready. Depends on sev_pkg.
`default_nettype none

module sev_skid (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [sev_pkg::OUT_W-1:0]  i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [sev_pkg::OUT_W-1:0]  o_data
);
    import sev_pkg::*;

    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic             r_sk_valid;
    logic [OUT_W-1:0] r_sk_data;

    assign o_ready = !r_sk_valid;

    // Control: the output register refills from the skid entry first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            r_out_valid <= r_sk_valid || i_valid;
            r_sk_valid  <= 1'b0;
        end else if (i_valid && !r_sk_valid) begin
            r_sk_valid  <= 1'b1;
        end
    end

    // Payload follows the same choices.
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out_data <= r_sk_valid ? r_sk_data : i_data;
        end else if (i_valid && !r_sk_valid) begin
            r_sk_data  <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

`default_nettype wire

// ===== sim/sev_checker.sv =====
// Scoreboard for the Smagorinsky eddy viscosity block: watches the register port and
// both streams, predicts each result in fixed point and compares it on arrival.
// Depends on sev_pkg for the item layout, widths, register indexes and reset values.
module sev_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [sev_pkg::IN_W-1:0]      i_s_tdata,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [sev_pkg::OUT_W-1:0]     i_m_tdata,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [sev_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sev_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_open_count,
    output int                            o_checked,
    output int                            o_saturated
);
    timeunit 1ns;
    timeprecision 1ps;
    import sev_pkg::*;

    typedef struct {
        int               seq;
        logic [OUT_W-1:0] visc;
    } t_visc_entry;

    // Shadow copy of the block's registers.
    logic [CFG_W-1:0] mol_visc;
    logic [CFG_W-1:0] density;
    logic [CFG_W-1:0] coeff;

    t_visc_entry visc_q[$];
    int          fail_count = 0;
    int          open_count = 0;
    int          checked    = 0;
    int          saturated  = 0;
    int          point_seq  = 0;

    assign o_fail_count = fail_count;
    assign o_open_count = open_count;
    assign o_checked    = checked;
    assign o_saturated  = saturated;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("%0t ns MISMATCH: %s", $time, msg);
        fail_count++;
    endtask

    // Exact square of the magnitude of a signed value.
    function automatic logic [127:0] sq_mag(input longint v);
        logic [63:0] m;
        m = (v < 0) ? 64'(-v) : 64'(v);
        return {64'd0, m} * {64'd0, m};
    endfunction

    // Fixed-point product rounded toward zero, held at 64 bits of all ones.
    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = ({64'd0, a} * {64'd0, b}) >> FRAC_BITS;
        return (prod[127:64] != '0) ? '1 : prod[63:0];
    endfunction

    // Effective viscosity of one point under the current register values.
    function automatic logic [OUT_W-1:0] predict_visc(input t_in_item pt);
        logic [127:0] rad;
        logic [63:0]  root;
        logic [63:0]  cand;
        logic [63:0]  acc;
        logic [63:0]  h;
        logic [32:0]  total;
        // Twice the squared norm: diagonal squares doubled, plus full cross sums squared.
        rad = 2 * (sq_mag($signed(pt.dux_dx)) + sq_mag($signed(pt.dvy_dy))
                   + sq_mag($signed(pt.dwz_dz)))
            + sq_mag(longint'($signed(pt.dux_dy)) + longint'($signed(pt.dvy_dx)))
            + sq_mag(longint'($signed(pt.dux_dz)) + longint'($signed(pt.dwz_dx)))
            + sq_mag(longint'($signed(pt.dvy_dz)) + longint'($signed(pt.dwz_dy)));
        rad = rad >> 1;
        // Floor square root, one bit at a time from the top.
        root = '0;
        for (int b = NORM_W - 1; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if ({64'd0, cand} * {64'd0, cand} <= rad) begin
                root = cand;
            end
        end
        // Product chain in the block's order, each step truncated.
        h   = {32'd0, pt.elem_size};
        acc = fx_mul({32'd0, coeff}, {32'd0, coeff});
        acc = fx_mul(acc, h);
        acc = fx_mul(acc, h);
        acc = fx_mul(acc, {32'd0, density});
        acc = fx_mul(acc, root);
        if (acc >= 64'h0000_0000_FFFF_FFFF) begin
            return OUT_MAX;
        end
        total = {1'b0, mol_visc} + acc[32:0];
        if (total >= 33'h0_FFFF_FFFF) begin
            return OUT_MAX;
        end
        return total[OUT_W-1:0];
    endfunction

    // Every transaction is taken at the edge where its valid and ready are both high.
    always @(posedge i_clk) begin
        t_visc_entry exp_entry;
        if (!i_rst_n) begin
            mol_visc = RST_MOL_VISC;
            density  = RST_DENSITY;
            coeff    = RST_SMAG_COEFF;
            visc_q.delete();
        end else begin
            // Result side: compare with the oldest prediction.
            if (i_m_tvalid && i_m_tready) begin
                if (visc_q.size() == 0) begin
                    report_mismatch($sformatf("result %h arrived with nothing expected",
                                              i_m_tdata));
                end else begin
                    exp_entry = visc_q.pop_front();
                    checked++;
                    if (i_m_tdata !== exp_entry.visc) begin
                        report_mismatch($sformatf("point %0d eff_viscosity got %h expected %h",
                                                  exp_entry.seq, i_m_tdata, exp_entry.visc));
                    end
                end
            end
            // Point side: predict with the registers as they stand before this edge.
            if (i_s_tvalid && i_s_tready) begin
                exp_entry.seq  = point_seq;
                exp_entry.visc = predict_visc(t_in_item'(i_s_tdata));
                if (exp_entry.visc == OUT_MAX) begin
                    saturated++;
                end
                visc_q.push_back(exp_entry);
                point_seq++;
            end
            // Register writes; an index past the last register changes nothing.
            if (i_cfg_valid && i_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_MOL_VISC: begin
                        mol_visc = i_cfg_data;
                    end
                    CFG_DENSITY: begin
                        density = i_cfg_data;
                    end
                    CFG_SMAG_COEFF: begin
                        coeff = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
        open_count <= visc_q.size();
    end

endmodule

// ===== sim/testbench.sv =====
// Top of the eddy viscosity testbench: clock, reset, point and register stimulus,
// random back-pressure on the result stream, and the final verdict.
// Depends on sev_pkg, the smagorinsky_eddy_viscosity block and sev_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sev_pkg::*;

    localparam int NUM_PHASES      = 7;
    localparam int POINTS_PER_SET  = 100;
    localparam int DRAIN_CYCLES    = 60;
    localparam int TIMEOUT_NS      = 5_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [IN_W-1:0]      i_s_tdata   = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [OUT_W-1:0]     o_m_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    int fail_count;
    int open_count;
    int checked;
    int saturated;
    bit draining = 1'b0;
    bit no_gaps  = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    smagorinsky_eddy_viscosity dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    sev_checker #(.FRAC_BITS(16)) scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_open_count (open_count),
        .o_checked    (checked),
        .o_saturated  (saturated)
    );

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random point: gradients share one scale so the norm stays in a useful range,
    // with some full-range points and some cancelling or matching cross pairs.
    function automatic t_in_item rand_point();
        t_in_item pt;
        int       sh;
        sh = ($urandom_range(0, 99) < 15) ? 0 : $urandom_range(4, 28);
        for (int k = 0; k < 9; k++) begin
            pt[k*GRAD_W +: GRAD_W] = $unsigned($signed($urandom) >>> sh);
        end
        if ($urandom_range(0, 9) == 0) begin
            pt.dvy_dx = -pt.dux_dy;
        end
        if ($urandom_range(0, 9) == 0) begin
            pt.dwz_dx = pt.dux_dz;
        end
        pt.elem_size = ($urandom_range(0, 99) < 15) ? $urandom
                                                    : $urandom >> $urandom_range(6, 26);
        return pt;
    endfunction

    // Register values for each setting; the first four are the extremes.
    task automatic choose_settings(input int ph, output logic [CFG_W-1:0] mol,
                                   output logic [CFG_W-1:0] dens,
                                   output logic [CFG_W-1:0] cf);
        unique case (ph)
            0: begin
                mol = '0;  dens = '0;  cf = '1;
            end
            1: begin
                mol = '1;  dens = '1;  cf = '1;
            end
            2: begin
                mol = '0;  dens = 32'h0001_0000;  cf = '0;
            end
            3: begin
                mol = 32'hFFFF_FFFE;  dens = 32'd1;  cf = 32'h0001_0000;
            end
            4: begin
                mol = $urandom;  dens = $urandom;  cf = $urandom;
            end
            default: begin
                mol  = $urandom >> $urandom_range(8, 31);
                dens = $urandom_range(32'h0000_4000, 32'h0004_0000);
                cf   = $urandom_range(0, 32'h0000_8000);
            end
        endcase
    endtask

    // Holds one point on the stream until the block takes it; valid stays high after.
    task automatic send_point(input t_in_item pt, input int gap);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= pt;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // One register write transaction; the caller lowers valid after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Waits until every predicted result has been taken from the block.
    task automatic wait_idle();
        @(posedge i_clk);
        while (open_count != 0) @(posedge i_clk);
    endtask

    // Result stream back-pressure: ready runs broken by stalls of random length.
    initial begin
        int run;
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (draining) begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                run = $urandom_range(1, 40);
                i_m_tready <= 1'b1;
                repeat (run) @(posedge i_clk);
                stall = idle_len();
                if (stall > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    // Main stimulus: directed points under reset values, then directed and random register settings.
    initial begin
        t_in_item         pt;
        logic [CFG_W-1:0] mol;
        logic [CFG_W-1:0] dens;
        logic [CFG_W-1:0] cf;
        int               sent;
        sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero gradients and size.
        pt = '0;
        send_point(pt, idle_len());
        // Largest positive and most negative gradients with the largest size.
        for (int k = 0; k < 9; k++) pt[k*GRAD_W +: GRAD_W] = 32'h7FFF_FFFF;
        pt.elem_size = '1;
        send_point(pt, idle_len());
        for (int k = 0; k < 9; k++) pt[k*GRAD_W +: GRAD_W] = 32'h8000_0000;
        send_point(pt, idle_len());
        // Pure diagonal, unit size.
        pt = '0;
        pt.dux_dx = 32'h0001_0000;
        pt.dvy_dy = -32'sh0001_0000;
        pt.dwz_dz = 32'h0002_8000;
        pt.elem_size = 32'h0001_0000;
        send_point(pt, idle_len());
        // Cross gradients that cancel exactly.
        pt = '0;
        pt.dux_dy = 32'h7FFF_FFFF;  pt.dvy_dx = 32'h8000_0001;
        pt.dux_dz = 32'h1234_5678;  pt.dwz_dx = -32'sh1234_5678;
        pt.dvy_dz = 32'h8000_0001;  pt.dwz_dy = 32'h7FFF_FFFF;
        pt.elem_size = 32'h0001_0000;
        send_point(pt, idle_len());
        // Cross sums at both ends of their range.
        pt = '0;
        pt.dux_dy = 32'h8000_0000;  pt.dvy_dx = 32'h8000_0000;
        pt.dux_dz = 32'h8000_0000;  pt.dwz_dx = 32'h8000_0000;
        pt.dvy_dz = 32'h8000_0000;  pt.dwz_dy = 32'h8000_0000;
        pt.elem_size = 32'h0001_0000;
        send_point(pt, idle_len());
        pt.dux_dy = 32'h7FFF_FFFF;  pt.dvy_dx = 32'h7FFF_FFFF;
        pt.dux_dz = 32'h7FFF_FFFF;  pt.dwz_dx = 32'h7FFF_FFFF;
        pt.dvy_dz = 32'h7FFF_FFFF;  pt.dwz_dy = 32'h7FFF_FFFF;
        send_point(pt, idle_len());
        // Strong gradients with zero size.
        pt.elem_size = '0;
        send_point(pt, idle_len());
        // Alternating bit patterns with small sizes.
        for (int k = 0; k < 9; k++) pt[k*GRAD_W +: GRAD_W] = (k % 2) ? 32'hAAAA_AAAA
                                                                     : 32'h5555_5555;
        pt.elem_size = 32'd1;
        send_point(pt, idle_len());
        for (int k = 0; k < 9; k++) pt[k*GRAD_W +: GRAD_W] = (k % 2) ? 32'h5555_5555
                                                                     : 32'hAAAA_AAAA;
        pt.elem_size = 32'h0000_FFFF;
        send_point(pt, idle_len());
        // Each gradient alone.
        for (int k = 0; k < 9; k++) begin
            pt = '0;
            pt[k*GRAD_W +: GRAD_W] = (k % 2) ? 32'hFFFF_0000 : 32'h0003_0000;
            pt.elem_size = 32'h0002_0000;
            send_point(pt, idle_len());
        end
        sent = 19;
        i_s_tvalid <= 1'b0;

        // Random points under each register setting; writes only when idle.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            choose_settings(ph, mol, dens, cf);
            write_reg(CFG_MOL_VISC, mol);
            write_reg(CFG_DENSITY, dens);
            if (ph == 0 || $urandom_range(0, 1) == 1) begin
                write_reg(CFG_IDX_SPARE, $urandom);
            end
            write_reg(CFG_SMAG_COEFF, cf);
            i_cfg_valid <= 1'b0;
            for (int n = 0; n < POINTS_PER_SET; n++) begin
                if (n % 50 == 0) begin
                    no_gaps = ($urandom_range(0, 2) == 0);
                end
                send_point(rand_point(), no_gaps ? 0 : idle_len());
                sent++;
            end
            i_s_tvalid <= 1'b0;
        end

        // Drain: keep ready high, wait for every result, then a little longer.
        draining = 1'b1;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d points sent, %0d results checked under %0d register settings.",
                 sent, checked, NUM_PHASES + 1);
        $display("Summary: %0d results were saturated at full scale.", saturated);
        if (fail_count == 0 && open_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // Hard limit on the run in case the block stops answering.
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still expected.", open_count);
        $display("testbench failed");
        $finish;
    end

endmodule
